[rtl/core/daf_pkg.sv]
package daf_pkg;

    localparam int ADDR_W = 64;
    localparam int TASK_W = 64;

    // Table update chosen by the controller for the apply step.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_NEW_TASK,
        OP_SKIP,
        OP_HIT,
        OP_INSERT,
        OP_OVERWRITE
    } daf_op_t;

    typedef struct packed {
        logic    load;
        logic    match;
        daf_op_t op;
    } daf_cmd_t;

    typedef struct packed {
        logic task_change;
        logic addr_zero;
        logic hit;
        logic full;
    } daf_status_t;

endpackage

[rtl/core/duplicate_access_filter.sv]
// A word accepted with start is answered by a one-cycle done strobe after the match and apply states.
// A new word is not taken while busy; busy covers the compare and the table update.
// The compare against the valid table slots runs in the match state, the table update in the apply state.
// The receiver cannot stall: is_duplicate is valid only in the cycle that done is high.
// Reset (rst_n low, asynchronous) empties the table and sets the recorded task id to zero.
module duplicate_access_filter
    import daf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ADDR_W-1:0] access_address,
    input  logic              access_is_write,
    input  logic [TASK_W-1:0] task_ident,
    output logic              done,
    output logic              is_duplicate
);

    daf_cmd_t    cmd;
    daf_status_t status;

    daf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    daf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .access_address  (access_address),
        .access_is_write (access_is_write),
        .task_ident      (task_ident),
        .status          (status),
        .is_duplicate    (is_duplicate)
    );

endmodule

[rtl/core/daf_ctrl.sv]
module daf_ctrl
    import daf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  daf_status_t status,
    output daf_cmd_t    cmd,
    output logic        busy,
    output logic        done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    done_reg;
    daf_op_t op_sel;

    always_comb
    begin
        if (status.task_change)
        begin
            op_sel = OP_NEW_TASK;
        end
        else if (status.addr_zero)
        begin
            op_sel = OP_SKIP;
        end
        else if (status.hit)
        begin
            op_sel = OP_HIT;
        end
        else if (status.full)
        begin
            op_sel = OP_OVERWRITE;
        end
        else
        begin
            op_sel = OP_INSERT;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_APPLY);
        end
    end

    assign cmd.load  = (state_reg == ST_IDLE) && start;
    assign cmd.match = (state_reg == ST_MATCH);
    assign cmd.op    = (state_reg == ST_APPLY) ? op_sel : OP_NONE;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;

endmodule

[rtl/core/daf_datapath.sv]
module daf_datapath
    import daf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  daf_cmd_t          cmd,
    input  logic [ADDR_W-1:0] access_address,
    input  logic              access_is_write,
    input  logic [TASK_W-1:0] task_ident,
    output daf_status_t       status,
    output logic              is_duplicate
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [ADDR_W-1:0]        addr_reg;
    logic                     wr_reg;
    logic [TASK_W-1:0]        task_reg;

    logic [ADDR_W-1:0]        entry_addr_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] entry_wr_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [TASK_W-1:0]        cur_task_reg;

    logic [TABLE_ENTRIES-1:0] hit_reg;
    logic [TABLE_ENTRIES-1:0] hit_next;
    daf_status_t              status_reg;
    logic                     dup_reg;

    logic [TABLE_ENTRIES-1:0] shift_en;
    logic                     prev_wr;

    // Input capture and the parallel compare against every valid entry.
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_next[i] = (CNT_W'(i) < count_reg) && (entry_addr_reg[i] == addr_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg <= access_address;
            wr_reg   <= access_is_write;
            task_reg <= task_ident;
        end
        if (cmd.match)
        begin
            hit_reg                <= hit_next;
            status_reg.task_change <= (task_reg != cur_task_reg);
            status_reg.addr_zero   <= (addr_reg == '0);
            status_reg.hit         <= |hit_next;
            status_reg.full        <= (count_reg == CNT_W'(TABLE_ENTRIES));
        end
    end

    assign prev_wr = |(hit_reg & entry_wr_reg);

    // Slots that take the word of their front neighbor; slot zero takes the access.
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            case (cmd.op)
                OP_HIT:
                begin
                    shift_en[i] = |(hit_reg >> i);
                end
                OP_INSERT:
                begin
                    shift_en[i] = (CNT_W'(i) <= count_reg);
                end
                default:
                begin
                    shift_en[i] = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        case (cmd.op)
            OP_NEW_TASK:
            begin
                count_next = status_reg.addr_zero ? '0 : CNT_W'(1);
            end
            OP_INSERT:
            begin
                count_next = count_reg + CNT_W'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (shift_en[0])
        begin
            entry_addr_reg[0] <= addr_reg;
            entry_wr_reg[0]   <= wr_reg;
        end
        for (int i = 1; i < TABLE_ENTRIES; i++)
        begin
            if (shift_en[i])
            begin
                entry_addr_reg[i] <= entry_addr_reg[i-1];
                entry_wr_reg[i]   <= entry_wr_reg[i-1];
            end
        end
        if (cmd.op == OP_NEW_TASK)
        begin
            entry_addr_reg[0] <= addr_reg;
            entry_wr_reg[0]   <= wr_reg;
        end
        if (cmd.op == OP_OVERWRITE)
        begin
            entry_addr_reg[TABLE_ENTRIES-1] <= addr_reg;
            entry_wr_reg[TABLE_ENTRIES-1]   <= wr_reg;
        end
        if (cmd.op != OP_NONE)
        begin
            // A read followed by a write of the same address must be checked again.
            dup_reg <= (cmd.op == OP_HIT) && !(!prev_wr && wr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            cur_task_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.op == OP_NEW_TASK)
            begin
                cur_task_reg <= task_reg;
            end
        end
    end

    assign status       = status_reg;
    assign is_duplicate = dup_reg;

endmodule

[rtl/core/daf_checker.sv]
module daf_checker
    import daf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [ADDR_W-1:0] access_address,
    input logic              access_is_write,
    input logic [TASK_W-1:0] task_ident,
    input logic              done,
    input logic              is_duplicate
);

    logic accepted;

    assign accepted = start && !busy;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |=> busy)
        else $error("busy did not rise after an accepted word");

    a_done_after_three: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |-> ##3 done)
        else $error("no result three cycles after an accepted word");

    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accepted, 3))
        else $error("result without a matching accepted word");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

endmodule

bind duplicate_access_filter daf_checker u_daf_checker (.*);
